// ===== design/lpu8_pkg.sv =====
// shared types, constants and helpers for the length-prefixed utf8 string decoder
`timescale 1ns / 1ps
package lpu8_pkg;

  localparam int unsigned FifoDepthDefault = 2;

  localparam logic [7:0]  ContBit     = 8'h80;
  localparam logic [7:0]  LeadMask3   = 8'hE0;
  localparam logic [16:0] MaxLenReset = 17'd65536;
  localparam logic [16:0] MaxLenCap   = 17'd65536;
  localparam logic [16:0] DoneSat     = 17'd65536;
  localparam logic [2:0]  VarintGroups = 3'd5;

  // decoded event handed from front to back
  typedef struct packed {
    logic        empty_rec;
    logic        last;
    logic [15:0] unit;
    logic [30:0] len;
  } lpu8_evt_t;

  // number of characters that may be kept, from the max_length register
  function automatic logic [15:0] keep_limit(input logic [16:0] m);
    logic [16:0] mc;
    logic [16:0] lim;
    mc = m;
    if (mc == 17'd0) mc = 17'd1;
    if (mc > MaxLenCap) mc = MaxLenCap;
    lim = mc - 17'd1;
    return lim[15:0];
  endfunction

endpackage

// ===== design/lpu8_fifo.sv =====
// small event queue between the byte front end and the result back end
`timescale 1ns / 1ps
module lpu8_fifo #(
  parameter int unsigned Depth = lpu8_pkg::FifoDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lpu8_pkg::lpu8_evt_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output lpu8_pkg::lpu8_evt_t pop_data_o
);
  import lpu8_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  lpu8_evt_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntFull);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/lpu8_front.sv =====
// front end: varint length prefix and modified utf8 character assembly
`timescale 1ns / 1ps
module lpu8_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                fifo_full_i,
  output logic                push_o,
  output lpu8_pkg::lpu8_evt_t push_data_o
);
  import lpu8_pkg::*;

  typedef enum logic [1:0] {
    PH_LEN   = 2'b01,
    PH_CHARS = 2'b10
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [30:0] accum_q, accum_d;
  logic [2:0]  shift_q, shift_d;
  logic [30:0] left_q, left_d;
  logic [1:0]  pend_q, pend_d;
  logic [15:0] part_q, part_d;

  logic        accept;
  logic [30:0] grp;
  logic [30:0] accum_new;
  logic [15:0] unit;
  logic        done;
  logic [30:0] left_dec;
  lpu8_evt_t   evt;
  logic        evt_valid;

  assign in_ready_o = !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign grp        = {24'b0, data_byte_i[6:0]} << (5'd7 * {2'b0, shift_q});
  assign accum_new  = (shift_q < VarintGroups) ? (accum_q | grp) : accum_q;
  assign left_dec   = left_q - 31'd1;

  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    shift_d   = shift_q;
    left_d    = left_q;
    pend_d    = pend_q;
    part_d    = part_q;
    unit      = '0;
    done      = 1'b0;
    evt       = '0;
    evt_valid = 1'b0;
    case (phase_q)
      PH_LEN: begin
        accum_d = accum_new;
        if ((data_byte_i & ContBit) != 8'h00) begin
          if (shift_q < VarintGroups) shift_d = shift_q + 3'd1;
        end else begin
          shift_d = '0;
          if (accum_new == '0) begin
            evt.empty_rec = 1'b1;
            evt.last      = 1'b1;
            evt_valid     = 1'b1;
          end else begin
            phase_d = PH_CHARS;
            left_d  = accum_new;
            pend_d  = '0;
            part_d  = '0;
          end
        end
      end
      PH_CHARS: begin
        if (pend_q == 2'd0) begin
          if (!data_byte_i[7]) begin
            unit = {9'b0, data_byte_i[6:0]};
            done = 1'b1;
          end else if ((data_byte_i & LeadMask3) != LeadMask3) begin
            part_d = {5'b0, data_byte_i[4:0], 6'b0};
            pend_d = 2'd1;
          end else begin
            part_d = {data_byte_i[3:0], 12'b0};
            pend_d = 2'd2;
          end
        end else if (pend_q == 2'd2) begin
          part_d = part_q | {4'b0, data_byte_i[5:0], 6'b0};
          pend_d = 2'd1;
        end else begin
          unit   = part_q | {10'b0, data_byte_i[5:0]};
          pend_d = 2'd0;
          done   = 1'b1;
        end
        if (done) begin
          left_d    = left_dec;
          evt.unit  = unit;
          evt.len   = accum_q;
          evt.last  = (left_dec == '0);
          evt_valid = 1'b1;
          if (left_dec == '0) begin
            phase_d = PH_LEN;
            accum_d = '0;
            shift_d = '0;
            part_d  = '0;
          end
        end
      end
      default: begin
        phase_d = PH_LEN;
      end
    endcase
  end

  assign push_o      = accept && evt_valid;
  assign push_data_o = evt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      accum_q <= '0;
      shift_q <= '0;
      left_q  <= '0;
      pend_q  <= '0;
      part_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      part_q  <= part_d;
    end
  end

endmodule

// ===== design/lpu8_back.sv =====
// back end: keep decision, length clamp and output register
`timescale 1ns / 1ps
module lpu8_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [16:0]         cfg_max_length_i,
  input  logic                fifo_empty_i,
  input  lpu8_pkg::lpu8_evt_t pop_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         code_unit_o,
  output logic                unit_valid_o,
  output logic                record_end_o,
  output logic [15:0]         kept_length_o,
  output logic [30:0]         record_length_o
);
  import lpu8_pkg::*;

  logic [16:0] max_len_q;
  logic [16:0] done_q, done_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] unit_q;
  logic        uvalid_q, end_q;
  logic [15:0] kept_q;
  logic [30:0] len_q;

  logic [15:0] lim;
  logic        keep;
  logic        emit;
  logic [15:0] kept;

  assign lim   = keep_limit(max_len_q);
  assign keep  = !pop_data_i.empty_rec && (done_q < {1'b0, lim});
  assign emit  = keep || pop_data_i.last;
  assign kept  = (pop_data_i.len < {15'b0, lim}) ? pop_data_i.len[15:0] : lim;
  assign pop_o = !fifo_empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    done_d      = done_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (pop_o) begin
      if (!pop_data_i.empty_rec) begin
        if (pop_data_i.last) begin
          done_d = '0;
        end else if (done_q < DoneSat) begin
          done_d = done_q + 17'd1;
        end
      end
      if (emit) out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MaxLenReset;
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) max_len_q <= cfg_max_length_i;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only when a new result enters the output register
  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      unit_q   <= keep ? pop_data_i.unit : 16'h0000;
      uvalid_q <= keep;
      end_q    <= pop_data_i.last;
      kept_q   <= kept;
      len_q    <= pop_data_i.len;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign code_unit_o     = unit_q;
  assign unit_valid_o    = uvalid_q;
  assign record_end_o    = end_q;
  assign kept_length_o   = kept_q;
  assign record_length_o = len_q;

endmodule

// ===== design/length_prefixed_utf8_string_decoder_top.sv =====
// top level of the length-prefixed modified utf8 string decoder
// throughput: one byte per cycle, sustained, as long as results are taken
// a byte that completes a result is written into the event queue at its transfer;
//   the result then enters the back end output register once that register is free
// the event queue depth (FifoDepth) sets how long the back end may stall alone
// reset: async active low; expects a length prefix, max_length returns to 65536
`timescale 1ns / 1ps
module length_prefixed_utf8_string_decoder_top #(
  parameter int unsigned FifoDepth = lpu8_pkg::FifoDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel, always ready
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_max_length_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        unit_valid_o,
  output logic        record_end_o,
  output logic [15:0] kept_length_o,
  output logic [30:0] record_length_o
);
  import lpu8_pkg::*;

  logic      fifo_full, fifo_empty;
  logic      push, pop;
  lpu8_evt_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  // front: decodes varint prefix and character bytes, one event per finished
  // character or empty record
  lpu8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // short queue so the front keeps taking bytes while the output is stalled
  lpu8_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .empty_o     (fifo_empty),
    .pop_data_o  (pop_data)
  );

  // back: counts characters per record, drops the ones past the limit and
  // holds each result in the output register until its transfer
  lpu8_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i && cfg_ready_o),
    .cfg_max_length_i (cfg_max_length_i),
    .fifo_empty_i     (fifo_empty),
    .pop_data_i       (pop_data),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .code_unit_o      (code_unit_o),
    .unit_valid_o     (unit_valid_o),
    .record_end_o     (record_end_o),
    .kept_length_o    (kept_length_o),
    .record_length_o  (record_length_o)
  );

  // a dropped character only surfaces when it closes the record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !unit_valid_o |-> record_end_o)
    else $error("dropped result without record end");

  // a kept character implies a nonzero kept length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unit_valid_o |-> kept_length_o != 16'd0)
    else $error("kept character with zero kept length");

  // kept length never exceeds the record length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> {15'b0, kept_length_o} <= record_length_o)
    else $error("kept length above record length");

  // an empty record gives a closing result with no character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_length_o == 31'd0 |-> record_end_o && !unit_valid_o)
    else $error("empty record result malformed");

  // the front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full)
    else $error("event pushed into full queue");

endmodule
